// File: sv/amsc_pkg.sv
// ----------------------------------------------------------------------------
// amsc_pkg
// Shared types and constants for the accelerometer step counter.
// ----------------------------------------------------------------------------
package amsc_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int THRESH_BITS         = 11;
    localparam int THRESH_RESET        = 100;
    localparam int CFG_INDEX_BITS      = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_OFFSET  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_OFFSET  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_OFFSET  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH
    } state_t;

endpackage

// File: sv/accel_magnitude_step_counter.sv
// ----------------------------------------------------------------------------
// accel_magnitude_step_counter
// Offset-removed three-axis magnitude, two-sample smoothing and threshold
// step counting with a saturating step total.
// ----------------------------------------------------------------------------
// Each sample runs through a bit-serial sum of squares that walks the
// SAMPLE_BITS bits of each offset-removed axis value MSB first, for all
// three axes at once, then a restoring square root producing one result
// bit per cycle, then a finish state that updates the smoothing and step
// state once the output register is free. A new sample is taken once the
// previous one has reached the output register, which holds the result
// until it is taken.
module accel_magnitude_step_counter #(
    parameter int SAMPLE_BITS = amsc_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COUNT_BITS  = amsc_pkg::COUNT_BITS_DEFAULT,
    localparam int MAG_BITS   = SAMPLE_BITS + 1,
    localparam int CFG_BITS   = (SAMPLE_BITS > amsc_pkg::THRESH_BITS) ?
                                SAMPLE_BITS : amsc_pkg::THRESH_BITS,
    localparam int S_BITS     = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_BITS     = ((COUNT_BITS + MAG_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_BITS-1:0]                   s_tdata,  // x_sample, y_sample, z_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_BITS-1:0]                   m_tdata,  // step_count, smoothed_magnitude
    output logic                                m_tuser   // step_taken
);

    localparam int RAD_BITS = 2 * MAG_BITS;
    localparam int REM_BITS = MAG_BITS + 1;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);
    localparam int CMP_BITS = (MAG_BITS > amsc_pkg::THRESH_BITS) ?
                              MAG_BITS : amsc_pkg::THRESH_BITS;

    amsc_pkg::state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0]          x_off_reg, y_off_reg, z_off_reg;
    logic [amsc_pkg::THRESH_BITS-1:0] thr_reg;

    logic [SAMPLE_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [SAMPLE_BITS-1:0] mx_reg, my_reg, mz_reg;
    logic [SAMPLE_BITS-1:0] mx_next, my_next, mz_next;
    logic [RAD_BITS-1:0]    acc_reg, acc_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [MAG_BITS-1:0]    root_reg, root_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;

    logic [MAG_BITS-1:0]   prev_reg;
    logic                  armed_reg;
    logic [COUNT_BITS-1:0] total_reg;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_taken_reg;
    logic [MAG_BITS-1:0]   out_mag_reg;

    logic [SAMPLE_BITS-1:0] xs, ys, zs, dx, dy, dz;
    logic [RAD_BITS-1:0]    px, py, pz;
    logic [REM_BITS+1:0]    rem_t, trial;
    logic                   fits;
    logic [MAG_BITS:0]      avg_sum;
    logic [MAG_BITS-1:0]    avg;
    logic [CMP_BITS-1:0]    avg_c, thr_c;
    logic                   rise, fall;
    logic [COUNT_BITS-1:0]  total_next;
    logic                   armed_next;

    logic accept, load_out, sq_last, root_last;

    assign xs = s_tdata[SAMPLE_BITS-1:0];
    assign ys = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign zs = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    assign dx = (xs >= x_off_reg) ? (xs - x_off_reg) : (x_off_reg - xs);
    assign dy = (ys >= y_off_reg) ? (ys - y_off_reg) : (y_off_reg - ys);
    assign dz = (zs >= z_off_reg) ? (zs - z_off_reg) : (z_off_reg - zs);

    // MSB-first shift-add squaring
    assign px = mx_reg[SAMPLE_BITS-1] ? RAD_BITS'(dx_reg) : '0;
    assign py = my_reg[SAMPLE_BITS-1] ? RAD_BITS'(dy_reg) : '0;
    assign pz = mz_reg[SAMPLE_BITS-1] ? RAD_BITS'(dz_reg) : '0;

    // restoring square root step
    assign rem_t = {rem_reg, acc_reg[RAD_BITS-1:RAD_BITS-2]};
    assign trial = (REM_BITS + 2)'({root_reg, 2'b01});
    assign fits  = (rem_t >= trial);

    assign avg_sum = {1'b0, root_reg} + {1'b0, prev_reg};
    assign avg     = avg_sum[MAG_BITS:1];
    assign avg_c   = CMP_BITS'(avg);
    assign thr_c   = CMP_BITS'(thr_reg);
    assign rise    = (avg_c > thr_c) && !armed_reg;
    assign fall    = (avg_c < thr_c) && armed_reg;

    always_comb
    begin
        total_next = total_reg;
        armed_next = armed_reg;
        if (rise)
        begin
            armed_next = 1'b1;
            if (!(&total_reg))
            begin
                total_next = total_reg + 1'b1;
            end
        end
        else if (fall)
        begin
            armed_next = 1'b0;
        end
    end

    assign sq_last   = (cnt_reg == '0);
    assign root_last = (cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            amsc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = amsc_pkg::ST_SQUARE;
                end
            end
            amsc_pkg::ST_SQUARE:
            begin
                if (sq_last)
                begin
                    state_next = amsc_pkg::ST_ROOT;
                end
            end
            amsc_pkg::ST_ROOT:
            begin
                if (root_last)
                begin
                    state_next = amsc_pkg::ST_FINISH;
                end
            end
            amsc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = amsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amsc_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            amsc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            amsc_pkg::ST_FINISH:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // datapath
    always_comb
    begin
        mx_next   = mx_reg;
        my_next   = my_reg;
        mz_next   = mz_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            amsc_pkg::ST_IDLE:
            begin
                mx_next   = dx;
                my_next   = dy;
                mz_next   = dz;
                acc_next  = '0;
                rem_next  = '0;
                root_next = '0;
                cnt_next  = CNT_BITS'(SAMPLE_BITS - 1);
            end
            amsc_pkg::ST_SQUARE:
            begin
                mx_next  = {mx_reg[SAMPLE_BITS-2:0], 1'b0};
                my_next  = {my_reg[SAMPLE_BITS-2:0], 1'b0};
                mz_next  = {mz_reg[SAMPLE_BITS-2:0], 1'b0};
                acc_next = {acc_reg[RAD_BITS-2:0], 1'b0} + px + py + pz;
                cnt_next = sq_last ? CNT_BITS'(MAG_BITS - 1) : cnt_reg - 1'b1;
            end
            amsc_pkg::ST_ROOT:
            begin
                acc_next  = {acc_reg[RAD_BITS-3:0], 2'b00};
                rem_next  = fits ? REM_BITS'(rem_t - trial) : REM_BITS'(rem_t);
                root_next = {root_reg[MAG_BITS-2:0], fits};
                cnt_next  = cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amsc_pkg::ST_IDLE;
            x_off_reg     <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
            y_off_reg     <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
            z_off_reg     <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
            thr_reg       <= amsc_pkg::THRESH_BITS'(amsc_pkg::THRESH_RESET);
            prev_reg      <= '0;
            armed_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    amsc_pkg::CFG_X_OFFSET:  x_off_reg <= cfg_data[SAMPLE_BITS-1:0];
                    amsc_pkg::CFG_Y_OFFSET:  y_off_reg <= cfg_data[SAMPLE_BITS-1:0];
                    amsc_pkg::CFG_Z_OFFSET:  z_off_reg <= cfg_data[SAMPLE_BITS-1:0];
                    amsc_pkg::CFG_THRESHOLD: thr_reg <= cfg_data[amsc_pkg::THRESH_BITS-1:0];
                    default:                 thr_reg <= thr_reg;
                endcase
            end
            if (load_out)
            begin
                prev_reg      <= root_reg;
                armed_reg     <= armed_next;
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= dx;
            dy_reg <= dy;
            dz_reg <= dz;
        end
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mz_reg   <= mz_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (load_out)
        begin
            out_count_reg <= total_next;
            out_taken_reg <= rise;
            out_mag_reg   <= avg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_BITS'({out_mag_reg, out_count_reg});
    assign m_tuser  = out_taken_reg;

endmodule
